>>> design/ewma_thm_pkg.sv
// Shared types and constants for the EWMA threshold health monitor.
package ewma_thm_pkg;

  localparam int unsigned TempW   = 19;
  localparam int unsigned HumW    = 17;
  localparam int unsigned WeightW = 10;
  localparam int unsigned CountW  = 8;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned CfgW    = 19;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam logic [TempW-1:0]   DefTempDelta   = 19'd2000;
  localparam logic [HumW-1:0]    DefHumLimit    = 17'd85000;
  localparam logic [WeightW-1:0] DefWeight      = 10'd200;
  localparam logic [CountW-1:0]  DefCalibCount  = 8'd5;
  localparam logic [CountW-1:0]  DefAlertCount  = 8'd2;
  localparam logic [CountW-1:0]  DefRecovCount  = 8'd5;
  localparam logic [CountW-1:0]  RunMax         = 8'd255;
  localparam logic [WeightW-1:0] Permille       = 10'd1000;

  // floor(x / 1000) == (x * RecipMul) >> RecipShift for every x below 2^28
  localparam logic [28:0] RecipMul   = 29'd274877907;
  localparam int unsigned RecipShift = 38;

  typedef enum logic [AddrW-1:0] {
    REG_TEMP_DELTA  = 3'd0,
    REG_HUM_LIMIT   = 3'd1,
    REG_WEIGHT      = 3'd2,
    REG_CALIB_COUNT = 3'd3,
    REG_ALERT_COUNT = 3'd4,
    REG_RECOV_COUNT = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HS_CALIBRATING = 2'd0,
    HS_NORMAL      = 2'd1,
    HS_ALERT       = 2'd2
  } health_e;

  typedef struct packed {
    logic [TempW-1:0]   temp_delta;
    logic [HumW-1:0]    hum_limit;
    logic [WeightW-1:0] weight;
    logic [CountW-1:0]  calib_count;
    logic [CountW-1:0]  alert_count;
    logic [CountW-1:0]  recov_count;
  } cfg_t;

  typedef struct packed {
    health_e status;
    logic    changed;
  } health_res_t;

endpackage

>>> design/ewma_thm_cfg.sv
// Configuration register file; a zero write (or a weight above 1000) loads the default.
module ewma_thm_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ewma_thm_pkg::AddrW-1:0]        cfg_addr_i,
  input  logic [ewma_thm_pkg::CfgW-1:0]         cfg_wdata_i,
  output ewma_thm_pkg::cfg_t                    cfg_o
);

  ewma_thm_pkg::cfg_t cfg_q, cfg_d;

  logic [ewma_thm_pkg::HumW-1:0]    hum_v;
  logic [ewma_thm_pkg::WeightW-1:0] weight_v;
  logic [ewma_thm_pkg::CountW-1:0]  count_v;

  always_comb begin
    hum_v    = cfg_wdata_i[ewma_thm_pkg::HumW-1:0];
    weight_v = cfg_wdata_i[ewma_thm_pkg::WeightW-1:0];
    count_v  = cfg_wdata_i[ewma_thm_pkg::CountW-1:0];
    cfg_d    = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ewma_thm_pkg::REG_TEMP_DELTA:
          cfg_d.temp_delta = (cfg_wdata_i != '0) ? cfg_wdata_i : ewma_thm_pkg::DefTempDelta;
        ewma_thm_pkg::REG_HUM_LIMIT:
          cfg_d.hum_limit = (hum_v != '0) ? hum_v : ewma_thm_pkg::DefHumLimit;
        ewma_thm_pkg::REG_WEIGHT:
          cfg_d.weight = (weight_v != '0 && weight_v <= ewma_thm_pkg::Permille) ?
                         weight_v : ewma_thm_pkg::DefWeight;
        ewma_thm_pkg::REG_CALIB_COUNT:
          cfg_d.calib_count = (count_v != '0) ? count_v : ewma_thm_pkg::DefCalibCount;
        ewma_thm_pkg::REG_ALERT_COUNT:
          cfg_d.alert_count = (count_v != '0) ? count_v : ewma_thm_pkg::DefAlertCount;
        ewma_thm_pkg::REG_RECOV_COUNT:
          cfg_d.recov_count = (count_v != '0) ? count_v : ewma_thm_pkg::DefRecovCount;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_delta  <= ewma_thm_pkg::DefTempDelta;
      cfg_q.hum_limit   <= ewma_thm_pkg::DefHumLimit;
      cfg_q.weight      <= ewma_thm_pkg::DefWeight;
      cfg_q.calib_count <= ewma_thm_pkg::DefCalibCount;
      cfg_q.alert_count <= ewma_thm_pkg::DefAlertCount;
      cfg_q.recov_count <= ewma_thm_pkg::DefRecovCount;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/ewma_thm_detect.sv
// Temperature EWMA, deviation and threshold check.
module ewma_thm_detect (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   step_i,
  input  logic signed [ewma_thm_pkg::TempW-1:0]  temp_i,
  input  logic        [ewma_thm_pkg::HumW-1:0]   hum_i,
  input  ewma_thm_pkg::cfg_t                     cfg_i,
  output logic signed [ewma_thm_pkg::TempW-1:0]  avg_next_o,
  output logic        [ewma_thm_pkg::TempW-1:0]  dev_o,
  output logic                                   abnormal_o
);

  logic signed [ewma_thm_pkg::TempW-1:0] avg_q;
  logic                                  seeded_q;

  logic signed [ewma_thm_pkg::TempW-1:0] avg_eff;
  logic signed [ewma_thm_pkg::TempW:0]   diff;
  logic signed [10:0]                    keep_w;
  logic signed [10:0]                    new_w;
  logic signed [29:0]                    prod_keep;
  logic signed [29:0]                    prod_new;
  logic signed [29:0]                    acc;
  logic        [27:0]                    mag;
  logic        [56:0]                    quo_full;
  logic        [ewma_thm_pkg::TempW-1:0] quo;

  always_comb begin
    // first sample seeds the average, so its deviation is zero
    avg_eff = seeded_q ? avg_q : temp_i;
    diff    = {temp_i[ewma_thm_pkg::TempW-1], temp_i} - {avg_eff[ewma_thm_pkg::TempW-1], avg_eff};
    dev_o   = diff[ewma_thm_pkg::TempW] ? ewma_thm_pkg::TempW'(-diff)
                                        : diff[ewma_thm_pkg::TempW-1:0];
    abnormal_o = (dev_o >= cfg_i.temp_delta) || (hum_i >= cfg_i.hum_limit);

    new_w     = $signed({1'b0, cfg_i.weight});
    keep_w    = $signed({1'b0, ewma_thm_pkg::Permille}) - new_w;
    prod_keep = keep_w * avg_eff;
    prod_new  = new_w * temp_i;
    acc       = prod_keep + prod_new;

    // truncating divide by 1000 on the magnitude, sign restored after
    mag      = acc[29] ? 28'(-acc) : acc[27:0];
    quo_full = mag * ewma_thm_pkg::RecipMul;
    quo      = quo_full[56:ewma_thm_pkg::RecipShift];
    avg_next_o = acc[29] ? $signed(ewma_thm_pkg::TempW'(-quo)) : $signed(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q    <= '0;
      seeded_q <= 1'b0;
    end else if (step_i) begin
      avg_q    <= avg_next_o;
      seeded_q <= 1'b1;
    end
  end

endmodule

>>> design/ewma_thm_fsm.sv
// Health state machine with saturating sample and streak counters.
module ewma_thm_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      abnormal_i,
  input  ewma_thm_pkg::cfg_t        cfg_i,
  output ewma_thm_pkg::health_e     state_o,
  output ewma_thm_pkg::health_res_t res_o
);

  ewma_thm_pkg::health_e state_q, state_d;
  logic [ewma_thm_pkg::CountW-1:0] seen_q, seen_d;
  logic [ewma_thm_pkg::CountW-1:0] bad_q, bad_d;
  logic [ewma_thm_pkg::CountW-1:0] good_q, good_d;
  logic [ewma_thm_pkg::CountW-1:0] seen_inc, bad_inc, good_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ewma_thm_pkg::HS_CALIBRATING;
      seen_q  <= '0;
      bad_q   <= '0;
      good_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      seen_q  <= seen_d;
      bad_q   <= bad_d;
      good_q  <= good_d;
    end
  end

  always_comb begin
    seen_inc = (seen_q == ewma_thm_pkg::RunMax) ? seen_q : seen_q + 8'd1;
    bad_inc  = (bad_q  == ewma_thm_pkg::RunMax) ? bad_q  : bad_q  + 8'd1;
    good_inc = (good_q == ewma_thm_pkg::RunMax) ? good_q : good_q + 8'd1;
    state_d  = state_q;
    seen_d   = seen_inc;
    bad_d    = bad_q;
    good_d   = good_q;
    unique case (state_q)
      ewma_thm_pkg::HS_CALIBRATING: begin
        // streak counters hold while calibrating
        if (seen_inc >= cfg_i.calib_count) state_d = ewma_thm_pkg::HS_NORMAL;
      end
      ewma_thm_pkg::HS_NORMAL, ewma_thm_pkg::HS_ALERT: begin
        if (abnormal_i) begin
          good_d = '0;
          bad_d  = bad_inc;
          if (bad_inc >= cfg_i.alert_count) state_d = ewma_thm_pkg::HS_ALERT;
        end else begin
          bad_d  = '0;
          good_d = good_inc;
          if (state_q == ewma_thm_pkg::HS_ALERT && good_inc >= cfg_i.recov_count) begin
            state_d = ewma_thm_pkg::HS_NORMAL;
          end
        end
      end
      default: state_d = state_q;
    endcase
    res_o.status  = state_d;
    res_o.changed = (state_d != state_q);
  end

  assign state_o = state_q;

endmodule

>>> design/ewma_threshold_health_monitor.sv
// Top level: input register, single-pass update and result register.
// A sample accepted into the input register has its result loaded into the result register
// when it advances. Throughput: one sample per cycle while m_axis_tready_i stays high;
// the EWMA multiply and reciprocal divide sit between the input and result registers.
// s_axis_tready_o falls only when both registers hold transactions and the sink stalls.
// Reset (rst_ni low, asynchronous) clears the EWMA, counters, state and both valids,
// and loads the register defaults.
module ewma_threshold_health_monitor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [18:0] temperature_sample, [35:19] humidity_sample, [39:36] zero
  input  logic [ewma_thm_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [1:0] health_status, [20:2] smoothed_temperature, [39:21] temperature_deviation,
  // [40] status_changed, [41] sample_abnormal, [47:42] zero
  output logic [ewma_thm_pkg::OutDataW-1:0]    m_axis_tdata_o,
  input  logic                                 cfg_we_i,
  input  logic [ewma_thm_pkg::AddrW-1:0]       cfg_addr_i,
  input  logic [ewma_thm_pkg::CfgW-1:0]        cfg_wdata_i
);

  ewma_thm_pkg::cfg_t          cfg;
  ewma_thm_pkg::health_res_t   hres;
  ewma_thm_pkg::health_e       state_cur;

  logic                                  in_valid_q, in_valid_d;
  logic signed [ewma_thm_pkg::TempW-1:0] in_temp_q;
  logic        [ewma_thm_pkg::HumW-1:0]  in_hum_q;
  logic                                  out_valid_q, out_valid_d;
  logic [ewma_thm_pkg::OutDataW-1:0]     out_data_q, out_data_d;

  logic                                  advance;
  logic                                  in_take;
  logic signed [ewma_thm_pkg::TempW-1:0] avg_next;
  logic        [ewma_thm_pkg::TempW-1:0] dev;
  logic                                  abnormal;

  ewma_thm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ewma_thm_detect u_detect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .temp_i     (in_temp_q),
    .hum_i      (in_hum_q),
    .cfg_i      (cfg),
    .avg_next_o (avg_next),
    .dev_o      (dev),
    .abnormal_o (abnormal)
  );

  ewma_thm_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .abnormal_i (abnormal),
    .cfg_i      (cfg),
    .state_o    (state_cur),
    .res_o      (hres)
  );

  always_comb begin
    advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
    s_axis_tready_o = !in_valid_q || advance;
    in_take         = s_axis_tvalid_i && s_axis_tready_o;
    in_valid_d      = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d     = advance ? 1'b1 : ((m_axis_tready_i) ? 1'b0 : out_valid_q);
    out_data_d      = {6'b0, abnormal, hres.changed, dev, avg_next, hres.status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_temp_q <= $signed(s_axis_tdata_i[ewma_thm_pkg::TempW-1:0]);
      in_hum_q  <= s_axis_tdata_i[ewma_thm_pkg::TempW +: ewma_thm_pkg::HumW];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input register empty but not ready");

  a_advance_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o)
    else $error("processed transaction did not reach result register");

  a_changed_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (m_axis_tdata_o[40] == (m_axis_tdata_o[1:0] != $past(state_cur))))
    else $error("status_changed does not match state transition");

endmodule

>>> sim/ewma_threshold_health_monitor_tb.sv
// Self-checking stream testbench for the EWMA threshold health monitor.
`timescale 1ns / 100ps

module ewma_threshold_health_monitor_tb;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned MaxReports  = 40;
  localparam int          TempMin     = -262144;
  localparam int          TempMax     = 262143;
  localparam int unsigned HumFieldMax = 131071;
  // indexes past the register map; writes there must be dropped
  localparam logic [ewma_thm_pkg::AddrW-1:0] RegSpareLo = 3'd6;
  localparam logic [ewma_thm_pkg::AddrW-1:0] RegSpareHi = 3'd7;

  typedef logic [ewma_thm_pkg::CfgW-1:0] cfg_word_t;

  typedef enum logic [1:0] {
    BURST_NOISE,
    BURST_FAULT,
    BURST_QUIET
  } burst_e;

  // same layout as m_axis_tdata_o[41:0]
  typedef struct packed {
    logic                           sample_abnormal;
    logic                           status_changed;
    logic [ewma_thm_pkg::TempW-1:0] deviation;
    logic [ewma_thm_pkg::TempW-1:0] smoothed;
    ewma_thm_pkg::health_e          status;
  } health_report_t;

  logic                              clk_i           = 1'b0;
  logic                              rst_ni          = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  // [18:0] temperature_sample, [35:19] humidity_sample, [39:36] zero
  logic [ewma_thm_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  // [1:0] health_status, [20:2] smoothed_temperature, [39:21] temperature_deviation,
  // [40] status_changed, [41] sample_abnormal, [47:42] zero
  logic [ewma_thm_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                              cfg_we_i        = 1'b0;
  logic [ewma_thm_pkg::AddrW-1:0]    cfg_addr_i      = '0;
  logic [ewma_thm_pkg::CfgW-1:0]     cfg_wdata_i     = '0;

  ewma_threshold_health_monitor i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // shadow of the block's registers and tracking state
  ewma_thm_pkg::cfg_t    cfg_shadow;
  int                    ewma_temp;
  logic                  ewma_seeded;
  int unsigned           samples_seen;
  int unsigned           bad_streak;
  int unsigned           good_streak;
  ewma_thm_pkg::health_e health_mode;

  logic [ewma_thm_pkg::InDataW-1:0] sample_q[$];
  health_report_t                   report_q[$];
  health_report_t                   seen_report;
  health_report_t                   want_report;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned mismatches;
  int unsigned samples_taken;
  int unsigned reports_checked;
  int unsigned alert_entries;
  int unsigned settings_used;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ewma_thm_pkg::InDataW-1:0] pack_sample(input int temp,
                                                                   input int unsigned hum);
    pack_sample = '0;
    pack_sample[ewma_thm_pkg::TempW-1:0] = temp[ewma_thm_pkg::TempW-1:0];
    pack_sample[ewma_thm_pkg::TempW +: ewma_thm_pkg::HumW] = hum[ewma_thm_pkg::HumW-1:0];
  endfunction

  // Advance the health model by one sample and queue the report it should produce.
  task automatic predict_health(input logic [ewma_thm_pkg::InDataW-1:0] data);
    int                    t;
    int                    diff;
    int unsigned           hum;
    int unsigned           dev;
    longint                w;
    longint                acc;
    logic                  abnormal;
    ewma_thm_pkg::health_e prev;
    health_report_t        r;
    t    = int'($signed(data[ewma_thm_pkg::TempW-1:0]));
    hum  = 32'(data[ewma_thm_pkg::TempW +: ewma_thm_pkg::HumW]);
    prev = health_mode;
    if (!ewma_seeded) begin
      ewma_temp   = t;
      ewma_seeded = 1'b1;
    end
    diff     = t - ewma_temp;
    dev      = (diff < 0) ? -diff : diff;
    abnormal = (dev >= cfg_shadow.temp_delta) || (hum >= cfg_shadow.hum_limit);

    w   = longint'(cfg_shadow.weight);
    acc = (longint'(ewma_thm_pkg::Permille) - w) * ewma_temp + w * t;
    ewma_temp = int'(acc / 1000);  // signed divide truncates toward zero

    if (samples_seen < ewma_thm_pkg::RunMax) samples_seen++;

    // streaks are frozen while calibrating
    if (health_mode == ewma_thm_pkg::HS_CALIBRATING) begin
      if (samples_seen >= cfg_shadow.calib_count) health_mode = ewma_thm_pkg::HS_NORMAL;
    end else if (abnormal) begin
      good_streak = 0;
      if (bad_streak < ewma_thm_pkg::RunMax) bad_streak++;
      if (bad_streak >= cfg_shadow.alert_count) health_mode = ewma_thm_pkg::HS_ALERT;
    end else begin
      bad_streak = 0;
      if (good_streak < ewma_thm_pkg::RunMax) good_streak++;
      if (health_mode == ewma_thm_pkg::HS_ALERT && good_streak >= cfg_shadow.recov_count)
        health_mode = ewma_thm_pkg::HS_NORMAL;
    end
    if (health_mode == ewma_thm_pkg::HS_ALERT && prev != ewma_thm_pkg::HS_ALERT)
      alert_entries++;

    r.status          = health_mode;
    r.smoothed        = ewma_temp[ewma_thm_pkg::TempW-1:0];
    r.deviation       = dev[ewma_thm_pkg::TempW-1:0];
    r.status_changed  = (health_mode != prev);
    r.sample_abnormal = abnormal;
    report_q.push_back(r);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s expected %h got %h", $time, field, want, seen);
    end
  endtask

  // Leaves cfg_we_i high; program_regs drops it after the last write.
  task automatic write_reg(input logic [ewma_thm_pkg::AddrW-1:0] addr, input cfg_word_t value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    case (addr)
      ewma_thm_pkg::REG_TEMP_DELTA:
        cfg_shadow.temp_delta = (value[ewma_thm_pkg::TempW-1:0] != '0) ?
                                value[ewma_thm_pkg::TempW-1:0] : ewma_thm_pkg::DefTempDelta;
      ewma_thm_pkg::REG_HUM_LIMIT:
        cfg_shadow.hum_limit = (value[ewma_thm_pkg::HumW-1:0] != '0) ?
                               value[ewma_thm_pkg::HumW-1:0] : ewma_thm_pkg::DefHumLimit;
      ewma_thm_pkg::REG_WEIGHT:
        cfg_shadow.weight = (value[ewma_thm_pkg::WeightW-1:0] != '0 &&
                             value[ewma_thm_pkg::WeightW-1:0] <= ewma_thm_pkg::Permille) ?
                            value[ewma_thm_pkg::WeightW-1:0] : ewma_thm_pkg::DefWeight;
      ewma_thm_pkg::REG_CALIB_COUNT:
        cfg_shadow.calib_count = (value[ewma_thm_pkg::CountW-1:0] != '0) ?
                                 value[ewma_thm_pkg::CountW-1:0] : ewma_thm_pkg::DefCalibCount;
      ewma_thm_pkg::REG_ALERT_COUNT:
        cfg_shadow.alert_count = (value[ewma_thm_pkg::CountW-1:0] != '0) ?
                                 value[ewma_thm_pkg::CountW-1:0] : ewma_thm_pkg::DefAlertCount;
      ewma_thm_pkg::REG_RECOV_COUNT:
        cfg_shadow.recov_count = (value[ewma_thm_pkg::CountW-1:0] != '0) ?
                                 value[ewma_thm_pkg::CountW-1:0] : ewma_thm_pkg::DefRecovCount;
      default: ;
    endcase
  endtask

  task automatic program_regs(input cfg_word_t delta, input cfg_word_t hum,
                              input cfg_word_t weight, input cfg_word_t calib,
                              input cfg_word_t alert, input cfg_word_t recov);
    write_reg(ewma_thm_pkg::REG_TEMP_DELTA, delta);
    write_reg(ewma_thm_pkg::REG_HUM_LIMIT, hum);
    write_reg(ewma_thm_pkg::REG_WEIGHT, weight);
    write_reg(ewma_thm_pkg::REG_CALIB_COUNT, calib);
    write_reg(ewma_thm_pkg::REG_ALERT_COUNT, alert);
    write_reg(ewma_thm_pkg::REG_RECOV_COUNT, recov);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Wait until every queued sample went in and every report came out.
  task automatic drain();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid_i || report_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Bursts of steady samples and of faults around a wandering baseline, plus raw noise.
  task automatic queue_samples(input int n, input int unsigned fault_pct,
                               input int unsigned noise_pct);
    int          left;
    int          len;
    int          k;
    int          base;
    int          span;
    int          t;
    int          jump;
    int unsigned roll;
    int unsigned h;
    int unsigned hum_ok;
    burst_e      burst;
    left   = n;
    base   = int'($urandom_range(150000)) - 50000;
    span   = (cfg_shadow.temp_delta / 4 > 2000) ? 2000 : int'(cfg_shadow.temp_delta / 4);
    hum_ok = cfg_shadow.hum_limit - 1;
    @(negedge clk_i);
    while (left > 0) begin
      roll = $urandom_range(99);
      if ($urandom_range(9) == 0) base = int'($urandom_range(150000)) - 50000;
      if (roll < noise_pct) begin
        burst = BURST_NOISE;
        len   = $urandom_range(3, 1);
      end else if (roll < noise_pct + (100 - noise_pct) * fault_pct / 100) begin
        burst = BURST_FAULT;
        len   = $urandom_range(cfg_shadow.alert_count + 2, 1);
      end else begin
        burst = BURST_QUIET;
        len   = $urandom_range(cfg_shadow.recov_count + 2, 1);
      end
      for (k = 0; k < len && left > 0; k++) begin
        t = base + int'($urandom_range(2 * span)) - span;
        h = $urandom_range(hum_ok);
        case (burst)
          BURST_NOISE: begin
            t = int'($urandom_range(TempMax - TempMin)) + TempMin;
            h = $urandom_range(HumFieldMax);
          end
          BURST_FAULT: begin
            if ($urandom_range(1) == 1) begin
              h = $urandom_range(HumFieldMax, cfg_shadow.hum_limit);
            end else begin
              jump = int'(cfg_shadow.temp_delta) + int'($urandom_range(3000));
              t    = ($urandom_range(1) == 1) ? base + jump : base - jump;
            end
          end
          default: ;
        endcase
        if (t > TempMax) t = TempMax;
        if (t < TempMin) t = TempMin;
        sample_q.push_back(pack_sample(t, h));
        left--;
      end
    end
    drain();
  endtask

  // sender: holds a transaction until it is taken, then maybe idles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_health(s_axis_tdata_i);
        samples_taken++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= sample_q.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_report = health_report_t'(m_axis_tdata_o[$bits(health_report_t)-1:0]);
      reports_checked++;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result expected none got %h", $time, m_axis_tdata_o);
      end else begin
        want_report = report_q.pop_front();
        compare_field("health_status", want_report.status, seen_report.status);
        compare_field("smoothed_temperature", want_report.smoothed, seen_report.smoothed);
        compare_field("temperature_deviation", want_report.deviation, seen_report.deviation);
        compare_field("status_changed", want_report.status_changed,
                      seen_report.status_changed);
        compare_field("sample_abnormal", want_report.sample_abnormal,
                      seen_report.sample_abnormal);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, StallLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    cfg_shadow.temp_delta  = ewma_thm_pkg::DefTempDelta;
    cfg_shadow.hum_limit   = ewma_thm_pkg::DefHumLimit;
    cfg_shadow.weight      = ewma_thm_pkg::DefWeight;
    cfg_shadow.calib_count = ewma_thm_pkg::DefCalibCount;
    cfg_shadow.alert_count = ewma_thm_pkg::DefAlertCount;
    cfg_shadow.recov_count = ewma_thm_pkg::DefRecovCount;
    ewma_temp       = 0;
    ewma_seeded     = 1'b0;
    samples_seen    = 0;
    bad_streak      = 0;
    good_streak     = 0;
    health_mode     = ewma_thm_pkg::HS_CALIBRATING;
    mismatches      = 0;
    samples_taken   = 0;
    reports_checked = 0;
    alert_entries   = 0;
    settings_used   = 1;
    src_idle_pct    = 31;
    snk_idle_pct    = 76;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: seed, humidity at and over its limit while calibrating,
    // then large temperature swings push it into alert and the field extremes follow
    @(negedge clk_i);
    sample_q.push_back(pack_sample(25000, 40000));
    sample_q.push_back(pack_sample(25000, 85000));
    sample_q.push_back(pack_sample(25000, 84999));
    sample_q.push_back(pack_sample(26000, 100000));
    sample_q.push_back(pack_sample(24000, 0));
    sample_q.push_back(pack_sample(-100000, 0));
    sample_q.push_back(pack_sample(200000, HumFieldMax));
    sample_q.push_back(pack_sample(TempMin, 0));
    sample_q.push_back(pack_sample(TempMax, HumFieldMax));
    drain();

    // full weight: the average equals the last sample, so deviations land exactly
    program_regs(0, 0, 1000, 0, 0, 0);
    @(negedge clk_i);
    sample_q.push_back(pack_sample(25000, 40000));
    repeat (5) sample_q.push_back(pack_sample(25000, 40000));  // recovery
    sample_q.push_back(pack_sample(27000, 40000));             // deviation at threshold
    sample_q.push_back(pack_sample(27000, 40000));
    sample_q.push_back(pack_sample(25000, 40000));             // same, going down
    sample_q.push_back(pack_sample(26999, 84999));             // just below both limits
    sample_q.push_back(pack_sample(24000, 0));
    sample_q.push_back(pack_sample(26000, 0));                 // second fault -> alert
    drain();

    program_regs(500, 60000, 1, 0, 1, 1);
    queue_samples(120, 50, 15);
    program_regs(0, 0, 1000, 255, 3, 4);
    queue_samples(120, 40, 15);
    // everything abnormal: bad streak saturates; weight above range falls back
    program_regs(1, 1, 1023, 255, 255, 255);
    queue_samples(300, 100, 0);

    src_idle_pct = 76;
    snk_idle_pct = 31;
    // nothing can trip: good streak saturates on the way out of alert
    program_regs(19'h7FFFF, 17'h1FFFF, 1001, 0, 0, 255);
    queue_samples(300, 0, 0);
    program_regs(300000, 100000, 999, 1, 2, 3);
    queue_samples(150, 40, 20);
    write_reg(RegSpareLo, 19'h7FFFF);
    write_reg(RegSpareHi, 19'd1);
    program_regs(3000, 70000, 500, 7, 4, 2);
    queue_samples(150, 50, 15);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (3) begin
      program_regs(cfg_word_t'($urandom_range(8000)), cfg_word_t'($urandom_range(100000)),
                   cfg_word_t'($urandom_range(1023)), cfg_word_t'($urandom_range(255)),
                   cfg_word_t'($urandom_range(6)), cfg_word_t'($urandom_range(8)));
      queue_samples(120, $urandom_range(60, 20), $urandom_range(25, 5));
    end

    repeat (4) @(posedge clk_i);
    if (report_q.size() != 0) begin
      mismatches += report_q.size();
      $display("%0t: %0d results missing, first expected %h got none", $time,
               report_q.size(), report_q[0]);
    end
    $display("Run covered %0d samples and %0d checked results under %0d register settings.",
             samples_taken, reports_checked, settings_used);
    $display("Alert was entered %0d times; %0d field mismatches seen.", alert_entries,
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
design/ewma_thm_pkg.sv
design/ewma_thm_cfg.sv
design/ewma_thm_detect.sv
design/ewma_thm_fsm.sv
design/ewma_threshold_health_monitor.sv
sim/ewma_threshold_health_monitor_tb.sv
